// File: rtl/core/windowed_regression_clock_offset_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clock offset regression core
// Shorthand for clocked implication checks on clk with rst as disable.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_REGRESSION_CLOCK_OFFSET_CORE_ASSERT_SVH
`define WINDOWED_REGRESSION_CLOCK_OFFSET_CORE_ASSERT_SVH

// Same-cycle implication.
`define WRCO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WRCO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/wrco_pkg.sv
// ----------------------------------------------------------------------------
// wrco_pkg
// Constants and saturation helpers for the clock offset regression core.
// ----------------------------------------------------------------------------
package wrco_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int X_SHIFT_DEF      = 20;
  localparam int SLOPE_FRAC_DEF   = 32;
  localparam int SAMPLE_BITS      = 28;
  localparam int WIDE_W           = 128;
  localparam logic [6:0] WINDOW_RESET = 7'd60;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [63:0] word_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Saturate a wide signed value to the signed 64-bit range.
  function automatic word_t sat64(input wide_t a);
    word_t r;
    if ((&a[WIDE_W-1:63]) || !(|a[WIDE_W-1:63])) begin
      r = a[63:0];
    end else if (a[WIDE_W-1]) begin
      r = {1'b1, 63'd0};
    end else begin
      r = {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

  // Saturate a wide signed value to the signed sample range.
  function automatic sample_t clamp_sample(input wide_t a);
    sample_t r;
    if ((&a[WIDE_W-1:SAMPLE_BITS-1]) || !(|a[WIDE_W-1:SAMPLE_BITS-1])) begin
      r = a[SAMPLE_BITS-1:0];
    end else if (a[WIDE_W-1]) begin
      r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/windowed_regression_clock_offset_core.sv
// ----------------------------------------------------------------------------
// windowed_regression_clock_offset_core
// Sliding-window least-squares tracker of clock offset and drift.
// ----------------------------------------------------------------------------
// Usage notes.
// A timestamp word (send_time, remote_time, receive_time) is taken on the
// input channel when in_valid is high and in_stall is low. The core works on
// one word at a time and holds in_stall high until that word is finished.
// Each input word produces exactly one result word: the measured offset, the
// fitted slope and intercept, the predicted offset and the window fill.
// Each word passes through bookkeeping steps, sheds the oldest samples while
// the window is at its limit, forms six products on a serial shift-add
// multiplier and runs one or two 128-step restoring divisions. Samples live
// in one synchronous RAM. The result sits in an output register; a stalled
// receiver holds it, and a new input word may already be taken meanwhile,
// finishing only once the old result has left. Synchronous reset empties
// the window, restores a window length of 60 and drops any pending result.
// The window length is written over the cfg channel, which is always ready;
// the user must write it only while idle, as the core does not enforce this.
// ----------------------------------------------------------------------------
module windowed_regression_clock_offset_core #(
  parameter int WINDOW_DEPTH = wrco_pkg::WINDOW_DEPTH_DEF,
  parameter int X_SHIFT      = wrco_pkg::X_SHIFT_DEF,
  parameter int SLOPE_FRAC   = wrco_pkg::SLOPE_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  wrco_pkg::word_t       send_time,
  input  wrco_pkg::word_t       remote_time,
  input  wrco_pkg::word_t       receive_time,
  output logic                  out_valid,
  input  logic                  out_stall,
  output wrco_pkg::word_t       measured_offset,
  output wrco_pkg::word_t       fit_slope,
  output wrco_pkg::word_t       fit_intercept,
  output wrco_pkg::word_t       predicted_offset,
  output logic [6:0]            samples_held,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [6:0]            cfg_data
);
  import wrco_pkg::*;

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W = 10;
  localparam int SX_W  = SAMPLE_BITS + AW + 1;
  localparam int SQ_W  = 2 * SAMPLE_BITS + AW + 1;
  localparam int MEM_W = 2 * SAMPLE_BITS;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_OFS    = 5'd1;
  localparam logic [4:0] S_REB    = 5'd2;
  localparam logic [4:0] S_PROD   = 5'd3;
  localparam logic [4:0] S_DCHK   = 5'd4;
  localparam logic [4:0] S_DRD    = 5'd5;
  localparam logic [4:0] S_DMUL   = 5'd6;
  localparam logic [4:0] S_DSUB   = 5'd7;
  localparam logic [4:0] S_INS    = 5'd8;
  localparam logic [4:0] S_MSTART = 5'd9;
  localparam logic [4:0] S_MRUN   = 5'd10;
  localparam logic [4:0] S_MDONE  = 5'd11;
  localparam logic [4:0] S_DSTART = 5'd12;
  localparam logic [4:0] S_DRUN   = 5'd13;
  localparam logic [4:0] S_DDONE  = 5'd14;
  localparam logic [4:0] S_PRED   = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  localparam logic [2:0] PH_NXY  = 3'd0;
  localparam logic [2:0] PH_SXSY = 3'd1;
  localparam logic [2:0] PH_NXX  = 3'd2;
  localparam logic [2:0] PH_SXSX = 3'd3;
  localparam logic [2:0] PH_BSX  = 3'd4;
  localparam logic [2:0] PH_BX   = 3'd5;

  localparam logic DV_SLOPE = 1'b0;
  localparam logic DV_ICPT  = 1'b1;

  localparam logic [WIDE_W-1:0] X_MASK = (WIDE_W'(1) << X_SHIFT) - WIDE_W'(1);
  localparam logic [WIDE_W-1:0] F_MASK = (WIDE_W'(1) << SLOPE_FRAC) - WIDE_W'(1);

  logic [4:0] state;
  logic [2:0] phase;
  logic       div_sel;

  word_t t1, t2, t3;
  word_t offset, base_time, base_offset;
  sample_t sx, sy;
  logic signed [MEM_W-1:0] pxx, pxy;
  logic signed [SX_W-1:0] sum_x, sum_y;
  logic signed [SQ_W-1:0] sum_xx, sum_xy;
  logic [CNT_W-1:0] count;
  logic [AW-1:0] oldest;
  logic [6:0] wl;
  wide_t num, den, tmp;
  word_t slope, icpt, pred;

  // Serial multiplier.
  logic [WIDE_W-1:0] ma, acc;
  logic [63:0] mb;
  logic msign;

  // Restoring divider.
  logic [WIDE_W-1:0] dn, dd, rem, quo;
  logic [6:0] dcnt;
  logic dneg;

  // Sample RAM, x in the upper half.
  logic [MEM_W-1:0] ram [WINDOW_DEPTH];
  logic [MEM_W-1:0] rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // Window limit clamped to [2, WINDOW_DEPTH].
  logic [CMP_W-1:0] limit;
  always_comb begin
    if (wl < 7'd2) begin
      limit = CMP_W'(2);
    end else if (CMP_W'(wl) > CMP_W'(WINDOW_DEPTH)) begin
      limit = CMP_W'(WINDOW_DEPTH);
    end else begin
      limit = CMP_W'(wl);
    end
  end

  logic drop_now;
  assign drop_now = (CMP_W'(count) >= limit) && (count != '0);

  logic [AW+1:0] slot_sum;
  logic [AW-1:0] slot;
  always_comb begin
    slot_sum = (AW+2)'(oldest) + (AW+2)'(count);
    if (slot_sum >= (AW+2)'(WINDOW_DEPTH)) begin
      slot = AW'(slot_sum - (AW+2)'(WINDOW_DEPTH));
    end else begin
      slot = AW'(slot_sum);
    end
  end

  // Offset and rebasing arithmetic.
  wide_t diff, hsum, half, ofs_wide, dx, dx_adj, xq, dy;
  word_t ofs_now;
  always_comb begin
    diff     = WIDE_W'(t3) - WIDE_W'(t1);
    hsum     = diff + {{(WIDE_W-1){1'b0}}, diff[WIDE_W-1]};
    half     = hsum >>> 1;
    ofs_wide = WIDE_W'(t3) - WIDE_W'(t2) - half;
    ofs_now  = sat64(ofs_wide);
    dx       = WIDE_W'(t3) - WIDE_W'(base_time);
    dx_adj   = dx + (dx[WIDE_W-1] ? X_MASK : '0);
    xq       = dx_adj >>> X_SHIFT;
    dy       = WIDE_W'(offset) - WIDE_W'(base_offset);
  end

  // Narrow sample products, for an inserted or a dropped sample.
  sample_t qa, qb;
  logic signed [MEM_W-1:0] q_xx, q_xy;
  always_comb begin
    if (state == S_DMUL) begin
      qa = rdata[MEM_W-1:SAMPLE_BITS];
      qb = rdata[SAMPLE_BITS-1:0];
    end else begin
      qa = sx;
      qb = sy;
    end
    q_xx = qa * qa;
    q_xy = qa * qb;
  end

  // Multiplier operand selection.
  word_t op_a, op_b;
  always_comb begin
    case (phase)
      PH_NXY:  begin op_a = 64'(sum_xy); op_b = 64'(count); end
      PH_SXSY: begin op_a = 64'(sum_x);  op_b = 64'(sum_y);  end
      PH_NXX:  begin op_a = 64'(sum_xx); op_b = 64'(count); end
      PH_SXSX: begin op_a = 64'(sum_x);  op_b = 64'(sum_x);  end
      PH_BSX:  begin op_a = slope;       op_b = 64'(sum_x);  end
      default: begin op_a = slope;       op_b = 64'(sx);     end
    endcase
  end

  wide_t prod, den_new, quo_s, pr_adj, pr_q, pred_sum;
  logic [WIDE_W-1:0] r_shift;
  always_comb begin
    prod     = msign ? -acc : acc;
    den_new  = den - prod;
    quo_s    = dneg ? -quo : quo;
    r_shift  = {rem[WIDE_W-2:0], dn[WIDE_W-1]};
    pr_adj   = tmp + (tmp[WIDE_W-1] ? F_MASK : '0);
    pr_q     = pr_adj >>> SLOPE_FRAC;
    pred_sum = pr_q + WIDE_W'(base_offset) + WIDE_W'(icpt);
  end

  // Sample RAM: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state == S_INS) begin
      ram[slot] <= {sx, sy};
    end
    if (state == S_DRD) begin
      rdata <= ram[oldest];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_NXY;
      div_sel     <= DV_SLOPE;
      sum_x       <= '0;
      sum_y       <= '0;
      sum_xx      <= '0;
      sum_xy      <= '0;
      count       <= '0;
      oldest      <= '0;
      base_time   <= '0;
      base_offset <= '0;
      wl          <= WINDOW_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        wl <= cfg_data;
      end
      // A result leaving while the next one is ready is replaced in S_DONE.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            t1    <= send_time;
            t2    <= remote_time;
            t3    <= receive_time;
            state <= S_OFS;
          end
        end
        S_OFS: begin
          offset <= ofs_now;
          if (count == '0) begin
            base_time   <= t3;
            base_offset <= ofs_now;
          end
          state <= S_REB;
        end
        S_REB: begin
          sx    <= clamp_sample(xq);
          sy    <= clamp_sample(dy);
          state <= S_DCHK;
        end
        S_DCHK: begin
          state <= drop_now ? S_DRD : S_PROD;
        end
        S_DRD: begin
          state <= S_DMUL;
        end
        S_DMUL: begin
          pxx   <= q_xx;
          pxy   <= q_xy;
          state <= S_DSUB;
        end
        S_DSUB: begin
          sum_x  <= sum_x - SX_W'($signed(rdata[MEM_W-1:SAMPLE_BITS]));
          sum_y  <= sum_y - SX_W'($signed(rdata[SAMPLE_BITS-1:0]));
          sum_xx <= sum_xx - SQ_W'(pxx);
          sum_xy <= sum_xy - SQ_W'(pxy);
          count  <= count - CNT_W'(1);
          oldest <= (oldest == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest + AW'(1);
          state  <= S_DCHK;
        end
        S_PROD: begin
          pxx   <= q_xx;
          pxy   <= q_xy;
          state <= S_INS;
        end
        S_INS: begin
          sum_x  <= sum_x + SX_W'(sx);
          sum_y  <= sum_y + SX_W'(sy);
          sum_xx <= sum_xx + SQ_W'(pxx);
          sum_xy <= sum_xy + SQ_W'(pxy);
          count  <= count + CNT_W'(1);
          phase  <= PH_NXY;
          state  <= S_MSTART;
        end
        S_MSTART: begin
          ma    <= {64'd0, (op_a[63] ? 64'(-op_a) : 64'(op_a))};
          mb    <= op_b[63] ? 64'(-op_b) : 64'(op_b);
          msign <= op_a[63] ^ op_b[63];
          acc   <= '0;
          state <= S_MRUN;
        end
        S_MRUN: begin
          if (mb == '0) begin
            state <= S_MDONE;
          end else begin
            if (mb[0]) begin
              acc <= acc + ma;
            end
            ma <= ma << 1;
            mb <= mb >> 1;
          end
        end
        S_MDONE: begin
          case (phase)
            PH_NXY: begin
              num   <= prod;
              phase <= PH_SXSY;
              state <= S_MSTART;
            end
            PH_SXSY: begin
              num   <= num - prod;
              phase <= PH_NXX;
              state <= S_MSTART;
            end
            PH_NXX: begin
              den   <= prod;
              phase <= PH_SXSX;
              state <= S_MSTART;
            end
            PH_SXSX: begin
              den <= den_new;
              if (!den_new[WIDE_W-1] && (den_new != '0)) begin
                div_sel <= DV_SLOPE;
                state   <= S_DSTART;
              end else begin
                slope <= '0;
                phase <= PH_BSX;
                state <= S_MSTART;
              end
            end
            PH_BSX: begin
              tmp     <= (WIDE_W'(sum_y) <<< SLOPE_FRAC) - prod;
              div_sel <= DV_ICPT;
              state   <= S_DSTART;
            end
            default: begin
              tmp   <= prod;
              state <= S_PRED;
            end
          endcase
        end
        S_DSTART: begin
          if (div_sel == DV_SLOPE) begin
            dneg <= num[WIDE_W-1];
            dn   <= num[WIDE_W-1] ? -(num <<< SLOPE_FRAC) : (num <<< SLOPE_FRAC);
            dd   <= den;
          end else begin
            dneg <= tmp[WIDE_W-1];
            dn   <= tmp[WIDE_W-1] ? -tmp : tmp;
            dd   <= WIDE_W'(count) << SLOPE_FRAC;
          end
          rem   <= '0;
          quo   <= '0;
          dcnt  <= '0;
          state <= S_DRUN;
        end
        S_DRUN: begin
          if (r_shift >= dd) begin
            rem <= r_shift - dd;
            quo <= {quo[WIDE_W-2:0], 1'b1};
          end else begin
            rem <= r_shift;
            quo <= {quo[WIDE_W-2:0], 1'b0};
          end
          dn   <= dn << 1;
          dcnt <= dcnt + 7'd1;
          if (dcnt == 7'd127) begin
            state <= S_DDONE;
          end
        end
        S_DDONE: begin
          if (div_sel == DV_SLOPE) begin
            slope <= sat64(quo_s);
            phase <= PH_BSX;
          end else begin
            icpt  <= sat64(quo_s);
            phase <= PH_BX;
          end
          state <= S_MSTART;
        end
        S_PRED: begin
          pred  <= sat64(pred_sum);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            measured_offset  <= offset;
            fit_slope        <= slope;
            fit_intercept    <= icpt;
            predicted_offset <= pred;
            samples_held     <= 7'(count);
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "windowed_regression_clock_offset_core_assert.svh"

  // An accepted word always starts with the offset step.
  `WRCO_ASSERT_NEXT(a_accept_start, in_valid && !in_stall, state == S_OFS, "accept did not start work")
  // The slope division only ever runs on a positive denominator.
  `WRCO_ASSERT_NOW(a_den_pos, state == S_DDONE && div_sel == DV_SLOPE, !den[WIDE_W-1] && den != '0, "slope divisor not positive")
  // A finished word never reports an empty or overfull window.
  `WRCO_ASSERT_NOW(a_fill, state == S_DONE, count != '0 && CMP_W'(count) <= limit, "window fill out of range")

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the windowed least-squares clock offset core
// Drives timestamp words through the input channel, predicts every result
// word with an independent model of the window and the line fit, and checks
// each result field by field. The window length is changed between phases,
// including out-of-range values and a shrink below the held sample count.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wrco_pkg::*;

  localparam int XS = X_SHIFT_DEF;
  localparam int SF = SLOPE_FRAC_DEF;
  localparam wide_t W_MAX = 128'sh7fff_ffff_ffff_ffff;
  localparam wide_t W_MIN = -W_MAX - 1;
  localparam wide_t S_MAX = (128'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam wide_t S_MIN = -S_MAX - 1;
  localparam longint L_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint L_MIN = 64'sh8000_0000_0000_0000;

  // Idle patterns for the two channels.
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    word_t      offset;
    word_t      slope;
    word_t      icpt;
    word_t      pred;
    logic [6:0] held;
  } fit_result_t;

  // A directed row; typed rows carry a measured offset that is plain to see,
  // and the very first row after reset carries the whole result.
  typedef struct {
    longint snd;
    longint rem;
    longint rcv;
    bit     typed;
    bit     full;
    longint offset;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  word_t      send_time = '0;
  word_t      remote_time = '0;
  word_t      receive_time = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  word_t      measured_offset;
  word_t      fit_slope;
  word_t      fit_intercept;
  word_t      predicted_offset;
  logic [6:0] samples_held;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;

  windowed_regression_clock_offset_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .send_time       (send_time),
    .remote_time     (remote_time),
    .receive_time    (receive_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .measured_offset (measured_offset),
    .fit_slope       (fit_slope),
    .fit_intercept   (fit_intercept),
    .predicted_offset(predicted_offset),
    .samples_held    (samples_held),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the window: sample ring as queues, running sums, base point.
  longint     win_x[$];
  longint     win_y[$];
  longint     sum_x = 0, sum_y = 0, sum_xx = 0, sum_xy = 0;
  longint     base_t = 0, base_off = 0;
  logic [6:0] win_len = WINDOW_RESET;

  fit_result_t pending_fits[$];
  int          errors = 0;
  idle_mode_e  idle_mode = IDLE_NONE;
  int          hold_cycles = 0;

  function automatic word_t sat_word(input wide_t a);
    if (a > W_MAX) return L_MAX;
    if (a < W_MIN) return L_MIN;
    return word_t'(a);
  endfunction

  function automatic longint sat_sample(input wide_t a);
    if (a > S_MAX) return longint'(S_MAX);
    if (a < S_MIN) return longint'(S_MIN);
    return longint'(a);
  endfunction

  // Advances the shadow window by one timestamp word and returns the fit.
  function automatic fit_result_t fit_next(input longint t1, input longint t2,
                                           input longint t3);
    fit_result_t r;
    wide_t       half, num, den, acc;
    longint      x, y, ox, oy;
    int          limit, n;
    word_t       slope;
    half = (wide_t'(t3) - wide_t'(t1)) / wide_t'(2);
    r.offset = sat_word(wide_t'(t3) - wide_t'(t2) - half);
    if (win_x.size() == 0) begin
      base_t = t3;
      base_off = r.offset;
    end
    x = sat_sample(wide_t'(sat_word((wide_t'(t3) - wide_t'(base_t)) /
                                    (wide_t'(1) <<< XS))));
    y = sat_sample(wide_t'(r.offset) - wide_t'(base_off));
    limit = int'(win_len);
    if (limit < 2) limit = 2;
    if (limit > WINDOW_DEPTH_DEF) limit = WINDOW_DEPTH_DEF;
    // A shrunk window sheds its oldest samples before the new one goes in.
    while (win_x.size() >= limit) begin
      ox = win_x.pop_front();
      oy = win_y.pop_front();
      sum_x -= ox; sum_y -= oy; sum_xx -= ox * ox; sum_xy -= ox * oy;
    end
    win_x.push_back(x);
    win_y.push_back(y);
    sum_x += x; sum_y += y; sum_xx += x * x; sum_xy += x * y;
    n = win_x.size();
    num = wide_t'(n) * wide_t'(sum_xy) - wide_t'(sum_x) * wide_t'(sum_y);
    den = wide_t'(n) * wide_t'(sum_xx) - wide_t'(sum_x) * wide_t'(sum_x);
    // All x equal (or one sample) leaves a flat line.
    slope = '0;
    if (den > 0) slope = sat_word((num <<< SF) / den);
    acc = (wide_t'(sum_y) <<< SF) - wide_t'(slope) * wide_t'(sum_x);
    r.slope = slope;
    r.icpt = sat_word(acc / (wide_t'(n) <<< SF));
    r.pred = sat_word((wide_t'(slope) * wide_t'(x)) / (wide_t'(1) <<< SF) +
                      wide_t'(base_off) + wide_t'(r.icpt));
    r.held = 7'(n);
    return r;
  endfunction

  // Offers one word, holding it until the core takes it. Always entered and
  // left right after a rising edge, so in_valid is never dropped and raised
  // in the same step.
  task automatic send_word(input longint t1, input longint t2, input longint t3,
                           input bit typed, input bit full, input longint toff);
    int          gap;
    fit_result_t e;
    gap = 0;
    if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
      while ($urandom_range(99) < (idle_mode == IDLE_SENDER ? 72 : 19) && gap < 40)
        gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    send_time <= t1;
    remote_time <= t2;
    receive_time <= t3;
    do @(posedge clk); while (in_stall);
    e = fit_next(t1, t2, t3);
    if (typed) e.offset = toff;
    if (full) begin
      e.slope = '0; e.icpt = '0; e.pred = toff; e.held = 7'd1;
    end
    pending_fits.push_back(e);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk);
    // The core may still be finishing housekeeping after its last word.
    repeat (40) @(posedge clk);
  endtask

  task automatic write_window(input logic [6:0] len);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_len = len;
  endtask

  // Receiver: checks every result word against the oldest prediction and
  // draws its stall for the next cycle. A nonzero hold_cycles forces a long
  // back-pressure stretch so the core fills up and stalls its input.
  always @(posedge clk) begin
    fit_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_fits.size() == 0) begin
        $display("%0t: result word with nothing expected, offset %0d", $time,
                 measured_offset);
        errors++;
      end else begin
        e = pending_fits.pop_front();
        if (measured_offset !== e.offset) begin
          $display("%0t: measured_offset expected %0d actual %0d", $time, e.offset,
                   measured_offset);
          errors++;
        end
        if (fit_slope !== e.slope) begin
          $display("%0t: fit_slope expected %0d actual %0d", $time, e.slope, fit_slope);
          errors++;
        end
        if (fit_intercept !== e.icpt) begin
          $display("%0t: fit_intercept expected %0d actual %0d", $time, e.icpt,
                   fit_intercept);
          errors++;
        end
        if (predicted_offset !== e.pred) begin
          $display("%0t: predicted_offset expected %0d actual %0d", $time, e.pred,
                   predicted_offset);
          errors++;
        end
        if (samples_held !== e.held) begin
          $display("%0t: samples_held expected %0d actual %0d", $time, e.held,
                   samples_held);
          errors++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (idle_mode == IDLE_RECEIVER) begin
      out_stall <= ($urandom_range(99) < 72);
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall <= ($urandom_range(99) < 19);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog, sized from the slowest words times the item count, with margin.
  initial begin
    #300ms;
    $display("tb: failure");
    $finish;
  end

  stim_row_t directed[] = '{
    '{0, 0, 0, 1, 1, 0},              // first sample after reset: flat line at zero
    '{5, 1000, 5, 1, 0, -995},        // zero round trip
    '{1000, 0, 1000, 1, 0, 1000},     // x still zero: zero denominator
    '{0, 0, 3, 1, 0, 2},              // odd round trip truncates toward zero
    '{3, 0, 0, 1, 0, 1},              // negative round trip truncates toward zero
    '{L_MAX, L_MIN, L_MAX, 1, 0, L_MAX},   // offset saturates high
    '{L_MIN, L_MAX, L_MIN, 1, 0, L_MIN},   // offset saturates low
    '{L_MIN, 0, L_MAX, 1, 0, 0},      // widest round trip
    '{L_MAX, 0, L_MIN, 1, 0, -1},     // widest negative round trip
    '{-1, -1, -1, 1, 0, 0},
    '{0, 0, 64'sd1 << 21, 0, 0, 0},
    '{0, 700, 64'sd2 << 21, 0, 0, 0},
    '{0, 950, 64'sd3 << 21, 0, 0, 0},
    '{0, -300, 64'sd5 << 21, 0, 0, 0},
    '{0, 20, 64'sd8 << 21, 0, 0, 0},
    '{L_MAX, 12345, L_MIN, 0, 0, 0},
    '{-77, 98765, 64'sd40 << 30, 0, 0, 0}
  };

  logic [6:0] window_plan[] = '{7'd2, 7'd127, 7'd0, 7'd1, 7'd64, 7'd3, 7'd33,
                                7'd60, 7'd17};

  initial begin
    longint now_t, skew, rtt, t1, t2, t3;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_word(directed[i].snd, directed[i].rem, directed[i].rcv, directed[i].typed,
                directed[i].full, directed[i].offset);

    now_t = $urandom();
    skew = $signed($urandom());
    foreach (window_plan[p]) begin
      // The first write shrinks the window well below the held count.
      write_window(window_plan[p]);
      idle_mode = idle_mode_e'(p % 4);
      if (p == 4) hold_cycles = 3000;
      for (int k = 0; k < 180; k++) begin
        if ($urandom_range(99) < 85) begin
          // A plausible exchange: steady time base with drifting skew.
          now_t += $urandom_range(1, 1 << 26);
          skew += $signed($urandom_range(0, 2000)) - 1000;
          rtt = $urandom_range(0, 1 << 20);
          t1 = now_t;
          t3 = now_t + rtt;
          t2 = now_t + rtt / 2 - skew + $signed($urandom_range(0, 64)) - 32;
          if ($urandom_range(99) < 3) now_t += {$urandom(), $urandom()} >> 20;
        end else begin
          t1 = {$urandom(), $urandom()};
          t2 = {$urandom(), $urandom()};
          t3 = ($urandom_range(1)) ? {$urandom(), $urandom()} : now_t;
        end
        send_word(t1, t2, t3, 1'b0, 1'b0, 0);
      end
    end

    drain_results();
    repeat (700) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
